@@ design/caption_pes_data_unit_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// Caption PES extractor assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CAPTION_PES_DATA_UNIT_EXTRACTOR_MACROS_SVH
`define CAPTION_PES_DATA_UNIT_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define CPX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CPX_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define CPX_ASSERT(label, prop, msg)
`define CPX_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ design/cpx_pkg.sv @@
// ----------------------------------------------------------------------------
// Caption PES extractor package
// Phase codes, event codes and command/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cpx_pkg;
	localparam logic [4:0] PH_DID = 5'd0, PH_PSID = 5'd1, PH_HLEN = 5'd2, PH_HSKIP = 5'd3,
		PH_GRP = 5'd4, PH_TMD = 5'd5, PH_TIME = 5'd6, PH_NLANG = 5'd7, PH_LANG = 5'd8,
		PH_LANGDC = 5'd9, PH_LANGREST = 5'd10, PH_LOOPLEN = 5'd11, PH_SEP = 5'd12,
		PH_PARAM = 5'd13, PH_USIZE = 5'd14, PH_BODY = 5'd15, PH_SKIPUNIT = 5'd16,
		PH_NCODE = 5'd17, PH_CCODE = 5'd18, PH_FONT = 5'd19, PH_PDIM = 5'd20,
		PH_PDATA = 5'd21, PH_GEOHDR = 5'd22, PH_GDATA = 5'd23, PH_DONE = 5'd24,
		PH_DROP = 5'd25, PH_MUL = 5'd26;
	localparam logic [1:0] EV_BODY = 2'd0, EV_DONE = 2'd1, EV_REJ = 2'd2, EV_EARLY = 2'd3;

	typedef struct packed {
		logic [4:0] phase;
		logic       step;
		logic       end_q;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  next_phase;
		logic        put_a;
		logic [1:0]  ev_a;
		logic        last_a;
		logic        mul_busy;
		logic        put_b;
	} stat_t;
endpackage
`default_nettype wire

@@ design/caption_pes_data_unit_extractor.sv @@
// ----------------------------------------------------------------------------
// Caption PES data unit extractor
// Parses caption PES bytes and passes statement body bytes out.
// ----------------------------------------------------------------------------
// Input channel: in_byte with packet_end, in_valid / in_stall. Output
// channel: event_res, body_byte, unit_last, out_valid / out_stall.
// One byte is taken per cycle while no result is queued and no multiply
// runs; a byte that makes results stalls input until they are all taken
// (one or two items, the second being group done after a final body byte
// or the early-end event).
// A result made by an accepted byte is presented in the cycle after it.
// The third DRCS pattern dimension byte starts a multiply of width,
// height and bits per pixel; input is held off while it runs.
// Reset returns the parser to packet start with the queue empty.
// When the receiver stalls, results wait in the queue and input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module caption_pes_data_unit_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       packet_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      event_res,
	output logic [7:0]      body_byte,
	output logic            unit_last
);
	cpx_pkg::cmd_t  cmd;
	cpx_pkg::stat_t stat;

	cpx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.packet_end(packet_end), .out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .body_byte(body_byte), .unit_last(unit_last),
		.in_byte(in_byte), .cmd(cmd), .stat(stat)
	);

	cpx_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_byte(in_byte), .stat(stat)
	);
endmodule
`default_nettype wire

@@ design/cpx_datapath.sv @@
// ----------------------------------------------------------------------------
// Caption PES extractor datapath
// Field registers, counters and next-phase decode for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "caption_pes_data_unit_extractor_macros.svh"
module cpx_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cpx_pkg::cmd_t cmd,
	input  wire logic [7:0]    in_byte,
	output cpx_pkg::stat_t     stat
);
	logic [23:0] field_count_q, loop_length_q, consumed_q, remaining_q;
	logic [7:0]  lang_q, fonts_q;
	logic [3:0]  mode_q;
	logic [15:0] dims_q;
	logic [1:0]  mul_cnt_q;
	logic [23:0] prod_q;

	logic [23:0] fc_n, ll_n, cons_n, rem_n, cons_inc, rem_dec;
	logic [7:0]  lang_n, fonts_n, lang_dec, fonts_dec;
	logic [3:0]  mode_n;
	logic [15:0] dims_n;
	logic [4:0]  ph_n;
	logic        put, put2, last;
	logic [1:0]  ev;
	logic        mul_start;
	logic [3:0]  bpp;
	logic [8:0]  lv;

	always_comb begin
		lv = {1'b0, dims_q[15:8]} + 9'd2;
		priority if (lv <= 9'd1) bpp = 4'd0;
		else if (lv <= 9'd2) bpp = 4'd1;
		else if (lv <= 9'd4) bpp = 4'd2;
		else if (lv <= 9'd8) bpp = 4'd3;
		else if (lv <= 9'd16) bpp = 4'd4;
		else if (lv <= 9'd32) bpp = 4'd5;
		else if (lv <= 9'd64) bpp = 4'd6;
		else if (lv <= 9'd128) bpp = 4'd7;
		else if (lv <= 9'd256) bpp = 4'd8;
		else bpp = 4'd9;
	end

	always_comb begin
		cons_inc = (cmd.phase >= cpx_pkg::PH_SEP && cmd.phase <= cpx_pkg::PH_GDATA &&
			consumed_q != 24'hFFFFFF) ? consumed_q + 24'd1 : consumed_q;
		fc_n = field_count_q; ll_n = loop_length_q; cons_n = cons_inc; rem_n = remaining_q;
		lang_n = lang_q; fonts_n = fonts_q; mode_n = mode_q; dims_n = dims_q;
		ph_n = cmd.phase; put = 1'b0; put2 = 1'b0; ev = cpx_pkg::EV_BODY; last = 1'b0;
		mul_start = 1'b0;
		rem_dec = remaining_q - 24'd1;
		lang_dec = lang_q - 8'd1;
		fonts_dec = fonts_q - 8'd1;
		unique case (cmd.phase)
			cpx_pkg::PH_DID: begin
				if (in_byte == 8'h80 || in_byte == 8'h81) ph_n = cpx_pkg::PH_PSID;
				else begin put = 1'b1; ev = cpx_pkg::EV_REJ; ph_n = cpx_pkg::PH_DROP; end
			end
			cpx_pkg::PH_PSID: begin
				if (in_byte == 8'hFF) ph_n = cpx_pkg::PH_HLEN;
				else begin put = 1'b1; ev = cpx_pkg::EV_REJ; ph_n = cpx_pkg::PH_DROP; end
			end
			cpx_pkg::PH_HLEN: begin
				rem_n = {20'd0, in_byte[3:0]}; fc_n = '0;
				ph_n = (in_byte[3:0] != 4'd0) ? cpx_pkg::PH_HSKIP : cpx_pkg::PH_GRP;
			end
			cpx_pkg::PH_HSKIP: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin ph_n = cpx_pkg::PH_GRP; fc_n = '0; end
			end
			cpx_pkg::PH_GRP: begin
				if (field_count_q == '0)
					mode_n = {3'd0, (in_byte[7:2] == 6'h00 || in_byte[7:2] == 6'h20)};
				fc_n = field_count_q + 24'd1;
				if (fc_n >= 24'd5) ph_n = cpx_pkg::PH_TMD;
			end
			cpx_pkg::PH_TMD: begin
				fc_n = '0;
				if (mode_q[0] ? (in_byte[7:6] == 2'd2) :
						(in_byte[7:6] == 2'd1 || in_byte[7:6] == 2'd2)) begin
					rem_n = 24'd5; ph_n = cpx_pkg::PH_TIME;
				end else ph_n = mode_q[0] ? cpx_pkg::PH_NLANG : cpx_pkg::PH_LOOPLEN;
			end
			cpx_pkg::PH_TIME: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					fc_n = '0; ph_n = mode_q[0] ? cpx_pkg::PH_NLANG : cpx_pkg::PH_LOOPLEN;
				end
			end
			cpx_pkg::PH_NLANG: begin
				lang_n = in_byte; fc_n = '0;
				ph_n = (in_byte != 8'd0) ? cpx_pkg::PH_LANG : cpx_pkg::PH_LOOPLEN;
			end
			cpx_pkg::PH_LANG: begin
				fc_n = '0;
				ph_n = (in_byte[3:0] == 4'hC || in_byte[3:0] == 4'hD || in_byte[3:0] == 4'hE)
					? cpx_pkg::PH_LANGDC : cpx_pkg::PH_LANGREST;
			end
			cpx_pkg::PH_LANGDC: begin fc_n = '0; ph_n = cpx_pkg::PH_LANGREST; end
			cpx_pkg::PH_LANGREST: begin
				fc_n = field_count_q + 24'd1;
				if (fc_n >= 24'd4) begin
					fc_n = '0; lang_n = lang_dec;
					ph_n = (lang_dec != 8'd0) ? cpx_pkg::PH_LANG : cpx_pkg::PH_LOOPLEN;
				end
			end
			cpx_pkg::PH_LOOPLEN: begin
				ll_n = (field_count_q == '0) ? {16'd0, in_byte} : {loop_length_q[15:0], in_byte};
				fc_n = field_count_q + 24'd1;
				if (fc_n >= 24'd3) begin
					cons_n = '0;
					if (ll_n != '0) ph_n = cpx_pkg::PH_SEP;
					else begin put = 1'b1; ev = cpx_pkg::EV_DONE; ph_n = cpx_pkg::PH_DONE; end
				end
			end
			cpx_pkg::PH_PARAM: begin
				mode_n = (in_byte == 8'h20) ? 4'd0 :
					((in_byte == 8'h30 || in_byte == 8'h31) ? 4'd1 : 4'd2);
				fc_n = '0; rem_n = '0; ph_n = cpx_pkg::PH_USIZE;
			end
			cpx_pkg::PH_USIZE: begin
				rem_n = {remaining_q[15:0], in_byte};
				fc_n = field_count_q + 24'd1;
				if (fc_n >= 24'd3) begin
					if (mode_q == 4'd1) ph_n = cpx_pkg::PH_NCODE;
					else if (rem_n == '0) ph_n = cpx_pkg::PH_SEP;
					else ph_n = (mode_q == 4'd0) ? cpx_pkg::PH_BODY : cpx_pkg::PH_SKIPUNIT;
				end
			end
			cpx_pkg::PH_BODY: begin
				rem_n = rem_dec; put = 1'b1; ev = cpx_pkg::EV_BODY; last = (rem_dec == '0);
				if (rem_dec == '0) ph_n = cpx_pkg::PH_SEP;
			end
			cpx_pkg::PH_SKIPUNIT: begin
				rem_n = rem_dec;
				if (rem_dec == '0) ph_n = cpx_pkg::PH_SEP;
			end
			cpx_pkg::PH_NCODE: begin
				lang_n = in_byte; fc_n = '0;
				ph_n = (in_byte == 8'd0) ? cpx_pkg::PH_SEP : cpx_pkg::PH_CCODE;
			end
			cpx_pkg::PH_CCODE: begin
				if (field_count_q < 24'd2) fc_n = field_count_q + 24'd1;
				else begin
					fonts_n = in_byte;
					if (in_byte != 8'd0) ph_n = cpx_pkg::PH_FONT;
					else begin
						lang_n = lang_dec;
						if (lang_dec != 8'd0) begin ph_n = cpx_pkg::PH_CCODE; fc_n = '0; end
						else ph_n = cpx_pkg::PH_SEP;
					end
				end
			end
			cpx_pkg::PH_FONT: begin
				mode_n = in_byte[3:0]; fc_n = '0; rem_n = '0;
				ph_n = (in_byte[3:0] <= 4'd1) ? cpx_pkg::PH_PDIM : cpx_pkg::PH_GEOHDR;
			end
			cpx_pkg::PH_PDIM: begin
				if (field_count_q == '0) begin dims_n = {in_byte, 8'd0}; fc_n = 24'd1; end
				else if (field_count_q == 24'd1) begin
					dims_n = {dims_q[15:8], in_byte}; fc_n = 24'd2;
				end else begin
					mul_start = 1'b1; ph_n = cpx_pkg::PH_MUL;
				end
			end
			cpx_pkg::PH_PDATA, cpx_pkg::PH_GDATA: begin
				rem_n = rem_dec;
				if (rem_dec == '0) ph_n = cpx_pkg::PH_FONT;
			end
			cpx_pkg::PH_GEOHDR: begin
				if (field_count_q < 24'd2) fc_n = field_count_q + 24'd1;
				else if (field_count_q == 24'd2) begin
					rem_n = {16'd0, in_byte}; fc_n = 24'd3;
				end else begin
					rem_n = {8'd0, remaining_q[7:0], in_byte};
					if (rem_n == '0) ph_n = cpx_pkg::PH_FONT;
					else ph_n = cpx_pkg::PH_GDATA;
				end
			end
			default: ;
		endcase
		// font_done / code_done / unit_end resolution for tail transitions
		if (ph_n == cpx_pkg::PH_FONT && (cmd.phase == cpx_pkg::PH_PDATA ||
				cmd.phase == cpx_pkg::PH_GDATA || cmd.phase == cpx_pkg::PH_GEOHDR)) begin
			fonts_n = fonts_dec;
			if (fonts_dec == 8'd0) begin
				lang_n = lang_dec;
				if (lang_dec != 8'd0) begin ph_n = cpx_pkg::PH_CCODE; fc_n = '0; end
				else ph_n = cpx_pkg::PH_SEP;
			end
		end
		if (ph_n == cpx_pkg::PH_SEP && cmd.phase != cpx_pkg::PH_LOOPLEN &&
				!(cmd.phase == cpx_pkg::PH_SEP && in_byte == 8'h1F)) begin
			if (!(cons_n < loop_length_q)) begin
				// a final body byte keeps its own item; group done follows it
				if (cmd.phase == cpx_pkg::PH_BODY) put2 = 1'b1;
				else begin put = 1'b1; ev = cpx_pkg::EV_DONE; end
				ph_n = cpx_pkg::PH_DONE;
			end
		end
		if (cmd.phase == cpx_pkg::PH_SEP) begin
			if (in_byte == 8'h1F) ph_n = cpx_pkg::PH_PARAM;
			else if (cons_n < loop_length_q) ph_n = cpx_pkg::PH_SEP;
			else begin put = 1'b1; ev = cpx_pkg::EV_DONE; ph_n = cpx_pkg::PH_DONE; end
		end
	end

	// width*height*bpp / 8 (bytes), staged through wh_s1 and prod_q after the height byte
	logic [15:0] wh_s1;
	logic [23:0] prod_full;
	logic [27:0] prod_bits;
	assign prod_bits = {12'd0, wh_s1} * {24'd0, bpp};
	assign prod_full = prod_bits[26:3];

	logic        mz_done;
	logic [23:0] mrem;
	always_comb begin
		mrem = prod_q;
		mz_done = 1'b0;
		if (mul_cnt_q == 2'd2 && prod_q == '0) mz_done = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= '0; loop_length_q <= '0; consumed_q <= '0; remaining_q <= '0;
			lang_q <= '0; fonts_q <= '0; mode_q <= '0; dims_q <= '0; mul_cnt_q <= '0;
		end else begin
			if (cmd.step) begin
				field_count_q <= fc_n; loop_length_q <= ll_n; consumed_q <= cons_n;
				remaining_q <= rem_n; lang_q <= lang_n; fonts_q <= fonts_n;
				mode_q <= mode_n; dims_q <= dims_n;
				if (mul_start) mul_cnt_q <= 2'd1;
			end else if (mul_cnt_q == 2'd1) begin
				mul_cnt_q <= 2'd2;
			end else if (mul_cnt_q == 2'd2) begin
				mul_cnt_q <= 2'd0;
				remaining_q <= mrem;
				if (mz_done) begin
					fonts_q <= fonts_dec;
					if (fonts_dec == 8'd0) lang_q <= lang_dec;
					if (fonts_dec == 8'd0 && lang_dec != 8'd0) field_count_q <= '0;
				end
			end
			if (cmd.end_q) field_count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && mul_start)
			wh_s1 <= {8'd0, dims_q[7:0]} * {8'd0, in_byte};
		if (mul_cnt_q == 2'd1) prod_q <= prod_full;
	end

	logic [4:0] mph;
	always_comb begin
		mph = cpx_pkg::PH_PDATA;
		if (mz_done) begin
			if (fonts_dec != 8'd0) mph = cpx_pkg::PH_FONT;
			else if (lang_dec != 8'd0) mph = cpx_pkg::PH_CCODE;
			else if (consumed_q < loop_length_q) mph = cpx_pkg::PH_SEP;
			else mph = cpx_pkg::PH_DONE;
		end
		stat.next_phase = (mul_cnt_q == 2'd2) ? mph : ph_n;
		stat.put_a = (mul_cnt_q == 2'd2) ? (mz_done && mph == cpx_pkg::PH_DONE) : put;
		stat.ev_a = (mul_cnt_q == 2'd2) ? cpx_pkg::EV_DONE : ev;
		stat.last_a = (mul_cnt_q == 2'd2) ? 1'b0 : last;
		stat.mul_busy = (mul_cnt_q != 2'd0);
		stat.put_b = (mul_cnt_q == 2'd2) ? 1'b0 : put2;
	end

	`CPX_ASSERT_NEXT(a_mul_seq, mul_cnt_q == 2'd1, mul_cnt_q == 2'd2, "multiply sequence broken")
	`CPX_ASSERT(a_no_step_in_mul, !(cmd.step && mul_cnt_q != 2'd0), "byte taken during multiply")
	`CPX_ASSERT(a_cons_le, (consumed_q <= 24'hFFFFFF), "consumed out of range")
endmodule
`default_nettype wire

@@ design/cpx_ctrl.sv @@
// ----------------------------------------------------------------------------
// Caption PES extractor controller
// Phase register, handshakes and the two-entry result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "caption_pes_data_unit_extractor_macros.svh"
module cpx_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           packet_end,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [1:0]          event_res,
	output logic [7:0]          body_byte,
	output logic                unit_last,
	input  wire logic [7:0]     in_byte,
	output cpx_pkg::cmd_t       cmd,
	input  wire cpx_pkg::stat_t stat
);
	logic [4:0]  phase_q;
	logic [1:0]  cnt_q;
	logic [10:0] q0_q, q1_q;
	logic        mul_end_q;
	logic        acc, pop, busy;
	logic        pa, pb;
	logic [10:0] ea, eb;
	logic [4:0]  ph_after;

	assign busy = stat.mul_busy;
	assign in_stall = busy || (cnt_q != 2'd0);
	assign acc = in_valid && !in_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign {event_res, body_byte, unit_last} = q0_q;

	always_comb begin
		cmd.phase = phase_q;
		cmd.step = acc;
		cmd.end_q = acc && packet_end && (stat.next_phase != cpx_pkg::PH_MUL);
		pa = 1'b0; pb = 1'b0; ea = '0; eb = '0;
		ph_after = phase_q;
		if (acc) begin
			pa = stat.put_a;
			ea = {stat.ev_a, (stat.ev_a == cpx_pkg::EV_BODY) ? in_byte : 8'd0, stat.last_a};
			pb = stat.put_b;
			eb = {cpx_pkg::EV_DONE, 9'd0};
			ph_after = stat.next_phase;
			if (packet_end && stat.next_phase != cpx_pkg::PH_MUL) begin
				if (stat.next_phase != cpx_pkg::PH_DONE && stat.next_phase != cpx_pkg::PH_DROP) begin
					if (pa) begin pb = 1'b1; eb = {cpx_pkg::EV_EARLY, 9'd0}; end
					else begin pa = 1'b1; ea = {cpx_pkg::EV_EARLY, 9'd0}; end
				end
				ph_after = cpx_pkg::PH_DID;
			end
		end else if (busy && stat.next_phase != cpx_pkg::PH_PDATA) begin
			pa = stat.put_a;
			ea = {cpx_pkg::EV_DONE, 9'd0};
		end
		if (busy) ph_after = stat.next_phase;
		if (busy && mul_end_q && ph_after != cpx_pkg::PH_MUL) begin
			if (pa) begin pb = (ph_after != cpx_pkg::PH_DONE); eb = {cpx_pkg::EV_EARLY, 9'd0}; end
			else if (ph_after != cpx_pkg::PH_DONE) begin
				pa = 1'b1; ea = {cpx_pkg::EV_EARLY, 9'd0};
			end
			ph_after = cpx_pkg::PH_DID;
		end
	end

	logic busy_end;
	assign busy_end = busy && (stat.next_phase != cpx_pkg::PH_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cpx_pkg::PH_DID; cnt_q <= '0; mul_end_q <= 1'b0;
		end else begin
			if (acc && stat.next_phase == cpx_pkg::PH_MUL) mul_end_q <= packet_end;
			if (acc || busy_end) phase_q <= ph_after;
			if (pop) begin
				cnt_q <= cnt_q - 2'd1 + {1'b0, pa} + {1'b0, pb};
			end else cnt_q <= cnt_q + {1'b0, pa} + {1'b0, pb};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) q0_q <= q1_q;
		end
		if (pa && cnt_q == 2'd0) q0_q <= ea;
		if (pb) q1_q <= eb;
	end

	`CPX_ASSERT(a_cnt_max, cnt_q <= 2'd2, "result queue overflow")
	`CPX_ASSERT_NEXT(a_pop_one, pop && cnt_q == 2'd2, cnt_q == 2'd1, "queue pop lost")
	`CPX_ASSERT(a_no_acc_pending, !(acc && cnt_q != 2'd0), "byte taken with results pending")
	`CPX_ASSERT(a_busy_end, !(busy_end && acc), "byte taken in multiply")
endmodule
`default_nettype wire
